@@ hw/rtl/pte_pkg.sv @@
// shared types and constants of the planar tile edit engine
package pte_pkg;

    localparam int TileCount = 256;
    localparam int TileBits  = $clog2(TileCount);
    localparam int AddrBits  = TileBits + 4;

    typedef enum logic [3:0] {
        OP_SET   = 4'd0,
        OP_GET   = 4'd1,
        OP_SWAP  = 4'd2,
        OP_FILL  = 4'd3,
        OP_HFLIP = 4'd4,
        OP_VFLIP = 4'd5,
        OP_DOWN  = 4'd6,
        OP_UP    = 4'd7,
        OP_LEFT  = 4'd8,
        OP_RIGHT = 4'd9,
        OP_COPY  = 4'd10,
        OP_PASTE = 4'd11,
        OP_WBYTE = 4'd12,
        OP_RBYTE = 4'd13,
        OP_NOP14 = 4'd14,
        OP_NOP15 = 4'd15
    } t_op;

    // classified command between front and back
    typedef struct packed {
        t_op           op;
        logic          skip;
        logic [7:0]    tile;
        logic [2:0]    px;
        logic [2:0]    py;
        logic [1:0]    ca;
        logic [1:0]    cb;
        logic [3:0]    bi;
        logic [7:0]    bd;
    } t_cmd;

    typedef struct packed {
        logic [1:0] color;
        logic [7:0] value;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT,
        ST_WORK,
        ST_STORE,
        ST_DONE
    } t_state;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int j = 0; j < 8; j++) begin
            r[7-j] = v[j];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/pte_front.sv @@
// command intake, classification and short command queue
module pte_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  pte_pkg::t_cmd    i_cmd,
    output logic             o_cmd_valid,
    output pte_pkg::t_cmd    o_cmd,
    input  logic             i_cmd_take
);

    pte_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    pte_pkg::t_cmd w_cls;
    logic          w_wr;
    logic          w_rd;

    // mark out-of-range tiles and unused codes as no-ops
    always_comb begin
        w_cls = i_cmd;
        w_cls.skip = ({1'b0, i_cmd.tile} >= 9'(pte_pkg::TileCount))
                     || (i_cmd.op == pte_pkg::OP_NOP14) || (i_cmd.op == pte_pkg::OP_NOP15);
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_cmd_take && o_cmd_valid;

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (w_wr) r_q[r_wp] <= w_cls;
    end

endmodule

@@ hw/rtl/pte_back.sv @@
// command execution over the tile store and clipboard
module pte_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  pte_pkg::t_cmd    i_cmd,
    output logic             o_cmd_take,
    output logic             o_res_valid,
    output pte_pkg::t_res    o_res,
    input  logic             i_res_free
);

    logic [7:0]   r_mem [pte_pkg::TileCount*16];
    logic [7:0]   r_rdata;
    logic [7:0]   r_tile [16];
    logic [7:0]   r_clip [16];
    logic [63:0]  r_match;
    logic [63:0]  r_region;
    logic [4:0]   r_idx;
    logic [3:0]   r_iter;
    logic [1:0]   r_color;
    logic [7:0]   r_value;
    pte_pkg::t_state r_st, n_st;
    pte_pkg::t_cmd   r_cmd;

    logic [pte_pkg::AddrBits-1:0] w_addr;
    logic        w_we;
    logic [7:0]  w_wdata;
    logic [63:0] w_grow;
    logic [1:0]  w_start;
    logic [5:0]  w_spos;

    assign w_addr  = {r_cmd.tile[pte_pkg::TileBits-1:0], r_idx[3:0]};
    assign w_spos  = {r_cmd.py, r_cmd.px};
    assign w_start = {r_tile[8 + 32'(r_cmd.py)][7 - 32'(r_cmd.px)],
                      r_tile[32'(r_cmd.py)][7 - 32'(r_cmd.px)]};
    assign o_cmd_take  = (r_st == pte_pkg::ST_IDLE) && i_cmd_valid && i_res_free;
    assign o_res_valid = (r_st == pte_pkg::ST_DONE);
    assign o_res       = '{color: r_color, value: r_value};

    // one growth step of the fill region
    always_comb begin
        for (int p = 0; p < 64; p++) begin
            w_grow[p] = r_match[p] && (r_region[p]
                || ((p % 8 != 0) && r_region[(p+63)%64])
                || ((p % 8 != 7) && r_region[(p+1)%64])
                || ((p >= 8) && r_region[(p+56)%64])
                || ((p < 56) && r_region[(p+8)%64]));
        end
    end

    // store write port
    always_comb begin
        w_we    = (r_st == pte_pkg::ST_STORE);
        w_wdata = r_tile[r_idx[3:0]];
        if (r_cmd.op == pte_pkg::OP_WBYTE) w_wdata = r_cmd.bd;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        r_rdata <= r_mem[w_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= pte_pkg::ST_IDLE;
        else          r_st <= n_st;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            pte_pkg::ST_IDLE: if (o_cmd_take) n_st = pte_pkg::ST_LOAD;
            pte_pkg::ST_LOAD: begin
                if (r_cmd.skip || r_cmd.op == pte_pkg::OP_PASTE) n_st = r_cmd.skip ?
                    pte_pkg::ST_DONE : pte_pkg::ST_WORK;
                else if (r_cmd.op == pte_pkg::OP_WBYTE) n_st = pte_pkg::ST_STORE;
                else n_st = pte_pkg::ST_WAIT;
            end
            pte_pkg::ST_WAIT: if (r_idx == 5'd16) n_st = pte_pkg::ST_WORK;
            pte_pkg::ST_WORK: begin
                // fill stays until nothing to do or the region stops growing
                if (r_cmd.op != pte_pkg::OP_FILL || w_start == r_cmd.ca
                    || (r_iter != 4'd0 && w_grow == r_region))
                    n_st = (r_cmd.op == pte_pkg::OP_GET || r_cmd.op == pte_pkg::OP_RBYTE
                            || r_cmd.op == pte_pkg::OP_COPY) ? pte_pkg::ST_DONE
                                                              : pte_pkg::ST_STORE;
            end
            pte_pkg::ST_STORE:
                if (r_cmd.op == pte_pkg::OP_WBYTE || r_idx[3:0] == 4'd15)
                    n_st = pte_pkg::ST_DONE;
            pte_pkg::ST_DONE: if (i_res_free) n_st = pte_pkg::ST_IDLE;
            default: n_st = pte_pkg::ST_IDLE;
        endcase
    end

    // datapath per state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_clip[k] <= 8'd0;
        end else begin
            unique case (r_st)
                pte_pkg::ST_IDLE: begin
                    r_cmd   <= i_cmd;
                    r_idx   <= 5'd0;
                    r_color <= 2'd0;
                    r_value <= 8'd0;
                end
                pte_pkg::ST_LOAD: begin
                    r_idx <= (r_cmd.op == pte_pkg::OP_WBYTE) ? {1'b0, r_cmd.bi} : 5'd1;
                    for (int k = 0; k < 16; k++) r_tile[k] <= r_clip[k];
                end
                pte_pkg::ST_WAIT: begin
                    // read data is registered, so it belongs to the previous address
                    r_tile[r_idx[3:0] - 4'd1] <= r_rdata;
                    r_idx <= r_idx + 5'd1;
                    r_iter <= 4'd0;
                end
                pte_pkg::ST_WORK: begin
                    r_idx <= 5'd0;
                    work_step();
                end
                pte_pkg::ST_STORE: r_idx <= r_idx + 5'd1;
                pte_pkg::ST_DONE: ;
                default: ;
            endcase
        end
    end

    // per-opcode tile work; fill iterates region growth to a fixed point
    task automatic work_step();
        logic [1:0] c;
        logic [63:0] m;
        unique case (r_cmd.op)
            pte_pkg::OP_SET: begin
                r_tile[r_cmd.py][7 - r_cmd.px]      <= r_cmd.ca[0];
                r_tile[8 + r_cmd.py][7 - r_cmd.px]  <= r_cmd.ca[1];
            end
            pte_pkg::OP_GET: r_color <= w_start;
            pte_pkg::OP_RBYTE: r_value <= r_tile[r_cmd.bi];
            pte_pkg::OP_SWAP: begin
                for (int y = 0; y < 8; y++) begin
                    for (int x = 0; x < 8; x++) begin
                        c = {r_tile[8+y][7-x], r_tile[y][7-x]};
                        if (c == r_cmd.ca) c = r_cmd.cb;
                        else if (c == r_cmd.cb) c = r_cmd.ca;
                        r_tile[y][7-x]   <= c[0];
                        r_tile[8+y][7-x] <= c[1];
                    end
                end
            end
            pte_pkg::OP_FILL: begin
                if (w_start == r_cmd.ca) begin
                    r_iter <= 4'd0;
                end else if (r_iter == 4'd0) begin
                    for (int p = 0; p < 64; p++) begin
                        m[p] = ({r_tile[8 + p/8][7 - p%8], r_tile[p/8][7 - p%8]} == w_start);
                    end
                    r_match  <= m;
                    r_region <= 64'd1 << w_spos;
                    r_iter   <= 4'd1;
                end else if (w_grow != r_region) begin
                    r_region <= w_grow;
                    r_iter   <= 4'd2;
                end else begin
                    for (int p = 0; p < 64; p++) begin
                        if (r_region[p]) begin
                            r_tile[p/8][7 - p%8]     <= r_cmd.ca[0];
                            r_tile[8 + p/8][7 - p%8] <= r_cmd.ca[1];
                        end
                    end
                    r_iter <= 4'd0;
                end
            end
            pte_pkg::OP_HFLIP:
                for (int k = 0; k < 16; k++) r_tile[k] <= pte_pkg::rev8(r_tile[k]);
            pte_pkg::OP_VFLIP:
                for (int k = 0; k < 8; k++) begin
                    r_tile[k]   <= r_tile[7-k];
                    r_tile[8+k] <= r_tile[15-k];
                end
            pte_pkg::OP_DOWN:
                for (int k = 0; k < 8; k++) begin
                    r_tile[k]   <= (k == 0) ? 8'd0 : r_tile[(k+7)%8];
                    r_tile[8+k] <= (k == 0) ? 8'd0 : r_tile[8+(k+7)%8];
                end
            pte_pkg::OP_UP:
                for (int k = 0; k < 8; k++) begin
                    r_tile[k]   <= (k == 7) ? 8'd0 : r_tile[(k+1)%8];
                    r_tile[8+k] <= (k == 7) ? 8'd0 : r_tile[8+(k+1)%8];
                end
            pte_pkg::OP_LEFT:
                for (int k = 0; k < 16; k++) r_tile[k] <= {r_tile[k][6:0], 1'b0};
            pte_pkg::OP_RIGHT:
                for (int k = 0; k < 16; k++) r_tile[k] <= {1'b0, r_tile[k][7:1]};
            pte_pkg::OP_COPY:
                for (int k = 0; k < 16; k++) r_clip[k] <= r_tile[k];
            pte_pkg::OP_PASTE, pte_pkg::OP_WBYTE, pte_pkg::OP_NOP14,
            pte_pkg::OP_NOP15: ;
            default: ;
        endcase
    endtask

endmodule

@@ hw/rtl/pte_out.sv @@
// result queue toward the consumer
module pte_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  pte_pkg::t_res  i_res,
    output logic           o_free,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [1:0]     o_pixel_color,
    output logic [7:0]     o_byte_value
);

    logic          r_full;
    pte_pkg::t_res r_res;

    assign o_free        = !r_full;
    assign o_empty       = !r_full;
    assign o_pixel_color = r_res.color;
    assign o_byte_value  = r_res.value;

    // single-entry result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_wr && !r_full) begin
            r_full <= 1'b1;
        end else if (i_pop && r_full) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && !r_full) r_res <= i_res;
    end

endmodule

@@ hw/rtl/planar_tile_edit_engine_top.sv @@
// top level of the planar tile edit engine
// Edits a store of 256 planar 2bpp 8x8 tiles; one result per command. The back end
// takes a command only once the previous result has been popped. An ignored command
// (tile out of range or unused code) goes straight to its result; a byte write stores
// one byte; get, read byte and copy read the tile, paste writes it, and an edit
// that rewrites the tile does both: the back end reads the tile's 16 bytes through
// the single store port one a cycle, works on them in registers and writes them
// back. A flood fill that changes something adds a setup step and growth steps
// until the region stops growing; a two-entry command queue holds waiting commands.
module planar_tile_edit_engine_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [3:0] i_opcode,
    input  logic [7:0] i_tile_index,
    input  logic [2:0] i_pixel_x,
    input  logic [2:0] i_pixel_y,
    input  logic [1:0] i_color_a,
    input  logic [1:0] i_color_b,
    input  logic [3:0] i_byte_index,
    input  logic [7:0] i_byte_data,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_pixel_color,
    output logic [7:0] o_byte_value
);

    pte_pkg::t_cmd w_in;
    pte_pkg::t_cmd w_cmd;
    pte_pkg::t_res w_res;
    logic w_cmd_valid, w_take, w_res_valid, w_free;

    assign w_in = '{op: pte_pkg::t_op'(i_opcode), skip: 1'b0, tile: i_tile_index,
                    px: i_pixel_x, py: i_pixel_y, ca: i_color_a, cb: i_color_b,
                    bi: i_byte_index, bd: i_byte_data};

    pte_front u_front (.i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_cmd(w_in),
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_take(w_take));

    pte_back u_back (.i_clk, .i_rst_n, .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd),
        .o_cmd_take(w_take), .o_res_valid(w_res_valid), .o_res(w_res),
        .i_res_free(w_free));

    pte_out u_out (.i_clk, .i_rst_n, .i_wr(w_res_valid), .i_res(w_res), .o_free(w_free),
        .o_empty(empty), .i_pop(pop), .o_pixel_color, .o_byte_value);

    // a command is only taken when the result slot is free
    a_take_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_free) else $error("command taken with result slot busy");

    // a nonempty output stays nonempty until popped, so no result is lost
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty) else $error("result lost");

endmodule

@@ bench/planar_tile_edit_engine_checker.sv @@
// checker of the planar tile edit engine: predicts each command's result and compares
`timescale 1ns / 1ps

module planar_tile_edit_engine_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [3:0] i_opcode,
    input  logic [7:0] i_tile_index,
    input  logic [2:0] i_pixel_x,
    input  logic [2:0] i_pixel_y,
    input  logic [1:0] i_color_a,
    input  logic [1:0] i_color_b,
    input  logic [3:0] i_byte_index,
    input  logic [7:0] i_byte_data,
    input  logic       empty,
    input  logic       pop,
    input  logic [1:0] i_pixel_color,
    input  logic [7:0] i_byte_value,
    output int         o_errors,
    output int         o_pending
);

    typedef logic [15:0][7:0] t_tile;

    logic [7:0]    tile_mem [pte_pkg::TileCount*16];
    t_tile         clip_tile;
    pte_pkg::t_res pending_results [$];

    // pixel color from the two planes
    function automatic logic [1:0] pix(t_tile t, int x, int y);
        return {t[8+y][7-x], t[y][7-x]};
    endfunction

    function automatic t_tile put(t_tile t, int x, int y, logic [1:0] c);
        t[y][7-x]   = c[0];
        t[8+y][7-x] = c[1];
        return t;
    endfunction

    // 4-neighbour flood fill over one tile
    function automatic t_tile flood(t_tile t, int sx, int sy, logic [1:0] rep);
        logic [1:0]  start;
        logic [63:0] match;
        logic [63:0] region;
        logic        grew;
        int          i;
        start = pix(t, sx, sy);
        if (start == rep) return t;
        match = '0;
        for (int y = 0; y < 8; y++)
            for (int x = 0; x < 8; x++)
                if (pix(t, x, y) == start) match[y*8+x] = 1'b1;
        region = '0;
        region[sy*8+sx] = 1'b1;
        grew = 1'b1;
        while (grew) begin
            grew = 1'b0;
            for (int y = 0; y < 8; y++)
                for (int x = 0; x < 8; x++) begin
                    i = y*8 + x;
                    if (match[i] && !region[i] &&
                        ((x > 0 && region[i-1]) || (x < 7 && region[i+1]) ||
                         (y > 0 && region[i-8]) || (y < 7 && region[i+8]))) begin
                        region[i] = 1'b1;
                        grew = 1'b1;
                    end
                end
        end
        for (int y = 0; y < 8; y++)
            for (int x = 0; x < 8; x++)
                if (region[y*8+x]) t = put(t, x, y, rep);
        return t;
    endfunction

    // apply one command to the predicted store and return its result
    function automatic pte_pkg::t_res edit_tile(pte_pkg::t_op op, int tile, int px, int py,
                                                logic [1:0] ca, logic [1:0] cb, int bi,
                                                logic [7:0] bd);
        pte_pkg::t_res res;
        t_tile         t;
        logic [1:0]    c;
        int            base;
        res  = '0;
        base = tile * 16;
        for (int k = 0; k < 16; k++) t[k] = tile_mem[base+k];
        case (op)
            pte_pkg::OP_SET:   t = put(t, px, py, ca);
            pte_pkg::OP_GET:   res.color = pix(t, px, py);
            pte_pkg::OP_SWAP: begin
                for (int x = 0; x < 8; x++)
                    for (int y = 0; y < 8; y++) begin
                        c = pix(t, x, y);
                        if (c == ca) t = put(t, x, y, cb);
                        else if (c == cb) t = put(t, x, y, ca);
                    end
            end
            pte_pkg::OP_FILL:  t = flood(t, px, py, ca);
            pte_pkg::OP_HFLIP: for (int k = 0; k < 16; k++) t[k] = {<<{t[k]}};
            pte_pkg::OP_VFLIP: for (int k = 0; k < 8; k++) begin
                t[k]   = tile_mem[base+7-k];
                t[8+k] = tile_mem[base+15-k];
            end
            pte_pkg::OP_DOWN: begin
                for (int k = 7; k >= 1; k--) begin
                    t[k]   = t[k-1];
                    t[8+k] = t[7+k];
                end
                t[0] = '0;
                t[8] = '0;
            end
            pte_pkg::OP_UP: begin
                for (int k = 0; k < 7; k++) begin
                    t[k]   = t[k+1];
                    t[8+k] = t[9+k];
                end
                t[7]  = '0;
                t[15] = '0;
            end
            pte_pkg::OP_LEFT:  for (int k = 0; k < 16; k++) t[k] = t[k] << 1;
            pte_pkg::OP_RIGHT: for (int k = 0; k < 16; k++) t[k] = t[k] >> 1;
            pte_pkg::OP_COPY:  clip_tile = t;
            pte_pkg::OP_PASTE: t = clip_tile;
            pte_pkg::OP_WBYTE: t[bi] = bd;
            pte_pkg::OP_RBYTE: res.value = t[bi];
            default: ;
        endcase
        for (int k = 0; k < 16; k++) tile_mem[base+k] = t[k];
        return res;
    endfunction

    assign o_pending = pending_results.size();

    // compare each result transfer, then predict each command transfer
    always @(posedge i_clk) begin
        pte_pkg::t_res want;
        if (!i_rst_n) begin
            clip_tile = '0;
            o_errors  = 0;
            pending_results.delete();
        end else begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with no command waiting");
                    o_errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_pixel_color !== want.color) begin
                        $error("pixel_color: expected %0d, actual %0d",
                               want.color, i_pixel_color);
                        o_errors++;
                    end
                    if (i_byte_value !== want.value) begin
                        $error("byte_value: expected %0h, actual %0h",
                               want.value, i_byte_value);
                        o_errors++;
                    end
                end
            end
            if (push && !full)
                pending_results.push_back(edit_tile(pte_pkg::t_op'(i_opcode), i_tile_index,
                    i_pixel_x, i_pixel_y, i_color_a, i_color_b, i_byte_index, i_byte_data));
        end
    end

endmodule

@@ bench/planar_tile_edit_engine_top_tb.sv @@
// testbench top of the planar tile edit engine: command stimulus and verdict
`timescale 1ns / 1ps

module planar_tile_edit_engine_top_tb;

    localparam int CycleLimit = 600000;
    localparam int RandomCmds = 830;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       pop = 1'b0;
    logic [3:0] i_opcode = '0;
    logic [7:0] i_tile_index = '0;
    logic [2:0] i_pixel_x = '0;
    logic [2:0] i_pixel_y = '0;
    logic [1:0] i_color_a = '0;
    logic [1:0] i_color_b = '0;
    logic [3:0] i_byte_index = '0;
    logic [7:0] i_byte_data = '0;
    logic       full;
    logic       empty;
    logic [1:0] o_pixel_color;
    logic [7:0] o_byte_value;
    int         errors;
    int         pending;
    int         cycles = 0;
    logic       calm = 1'b0;

    // bytes of each tile written so far, so no unwritten byte is ever read
    logic [15:0] written [256];

    planar_tile_edit_engine_top dut (
        .i_clk, .i_rst_n, .push, .full, .i_opcode, .i_tile_index, .i_pixel_x,
        .i_pixel_y, .i_color_a, .i_color_b, .i_byte_index, .i_byte_data,
        .empty, .pop, .o_pixel_color, .o_byte_value
    );

    planar_tile_edit_engine_checker checker_i (
        .i_clk, .i_rst_n, .push, .full, .i_opcode, .i_tile_index, .i_pixel_x,
        .i_pixel_y, .i_color_a, .i_color_b, .i_byte_index, .i_byte_data,
        .empty, .pop, .i_pixel_color(o_pixel_color), .i_byte_value(o_byte_value),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cycle count and timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off, one stretch always ready
    initial begin
        int n;
        n = 0;
        forever begin
            @(posedge i_clk);
            n++;
            if (n >= 2000 && n < 2600) pop <= 1'b0;
            else if (n >= 9000 && n < 15000) pop <= 1'b1;
            else pop <= ($urandom_range(0, 99) >= 35);
        end
    end

    // offer one command; a command that would read unwritten bytes becomes a paste
    task automatic send_cmd(pte_pkg::t_op op, logic [7:0] tile, logic [2:0] x,
                            logic [2:0] y, logic [1:0] ca, logic [1:0] cb,
                            logic [3:0] bi, logic [7:0] bd);
        int gap;
        if (written[tile] != 16'hFFFF && op != pte_pkg::OP_WBYTE &&
            op != pte_pkg::OP_NOP14 && op != pte_pkg::OP_NOP15 &&
            !(op == pte_pkg::OP_RBYTE && written[tile][bi]))
            op = pte_pkg::OP_PASTE;
        if (op == pte_pkg::OP_PASTE) written[tile] = 16'hFFFF;
        if (op == pte_pkg::OP_WBYTE) written[tile][bi] = 1'b1;
        gap = (!calm && $urandom_range(0, 99) < 35) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_opcode     <= op;
        i_tile_index <= tile;
        i_pixel_x    <= x;
        i_pixel_y    <= y;
        i_color_a    <= ca;
        i_color_b    <= cb;
        i_byte_index <= bi;
        i_byte_data  <= bd;
        do @(posedge i_clk); while (full);
    endtask

    // stimulus
    initial begin
        logic [7:0]   pool [8];
        logic [7:0]   tile;
        pte_pkg::t_op op;
        pool = '{8'd0, 8'd255, 8'd85, 8'd170, 8'd1, 8'd128, 8'd15, 8'd240};
        foreach (written[k]) written[k] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: loading, extremes, every operation and the no-change cases
        send_cmd(pte_pkg::OP_WBYTE, 8'd255, 3'd0, 3'd0, 2'd0, 2'd0, 4'd15, 8'hFF);
        send_cmd(pte_pkg::OP_RBYTE, 8'd255, 3'd0, 3'd0, 2'd0, 2'd0, 4'd15, 8'h00);
        send_cmd(pte_pkg::OP_PASTE, 8'd0, 3'd0, 3'd0, 2'd0, 2'd0, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_WBYTE, 8'd0, 3'd0, 3'd0, 2'd0, 2'd0, 4'd0, 8'hA5);
        send_cmd(pte_pkg::OP_WBYTE, 8'd0, 3'd0, 3'd0, 2'd0, 2'd0, 4'd15, 8'h5A);
        send_cmd(pte_pkg::OP_SET, 8'd0, 3'd7, 3'd7, 2'd3, 2'd0, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_SET, 8'd0, 3'd0, 3'd7, 2'd2, 2'd0, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_GET, 8'd0, 3'd7, 3'd7, 2'd0, 2'd0, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_GET, 8'd0, 3'd0, 3'd0, 2'd0, 2'd0, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_SWAP, 8'd0, 3'd0, 3'd0, 2'd1, 2'd1, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_SWAP, 8'd0, 3'd0, 3'd0, 2'd0, 2'd3, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_FILL, 8'd0, 3'd3, 3'd3, 2'd3, 2'd0, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_FILL, 8'd0, 3'd3, 3'd3, 2'd3, 2'd0, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_HFLIP, 8'd0, 3'd0, 3'd0, 2'd0, 2'd0, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_VFLIP, 8'd0, 3'd0, 3'd0, 2'd0, 2'd0, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_DOWN, 8'd0, 3'd0, 3'd0, 2'd0, 2'd0, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_UP, 8'd0, 3'd0, 3'd0, 2'd0, 2'd0, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_LEFT, 8'd0, 3'd0, 3'd0, 2'd0, 2'd0, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_RIGHT, 8'd0, 3'd0, 3'd0, 2'd0, 2'd0, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_COPY, 8'd0, 3'd0, 3'd0, 2'd0, 2'd0, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_PASTE, 8'd255, 3'd0, 3'd0, 2'd0, 2'd0, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_RBYTE, 8'd255, 3'd0, 3'd0, 2'd0, 2'd0, 4'd0, 8'h00);
        send_cmd(pte_pkg::OP_NOP14, 8'd0, 3'd7, 3'd7, 2'd3, 2'd3, 4'd15, 8'hFF);
        send_cmd(pte_pkg::OP_NOP15, 8'd255, 3'd0, 3'd0, 2'd0, 2'd0, 4'd0, 8'h00);

        // random commands, mostly on a small pool of tiles so edits pile up
        for (int n = 0; n < RandomCmds; n++) begin
            calm = (n >= 300 && n < 420);
            tile = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 7)]
                                                : 8'($urandom_range(0, 255));
            op = pte_pkg::t_op'($urandom_range(0, 99) < 5 ? $urandom_range(14, 15)
                                                          : $urandom_range(0, 13));
            send_cmd(op, tile, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                     2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        end
        push <= 1'b0;

        // drain, then let the block settle
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pte_pkg.sv
hw/rtl/pte_front.sv
hw/rtl/pte_back.sv
hw/rtl/pte_out.sv
hw/rtl/planar_tile_edit_engine_top.sv
bench/planar_tile_edit_engine_checker.sv
bench/planar_tile_edit_engine_top_tb.sv
